// ===== design/obe_pkg.sv =====
// ----------------------------------------------------------------------------
// obe_pkg: shared types and constants for the oriented box extent block
// Axis, projection, snapshot and result types, saturation limits, register
// indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package obe_pkg;

  // Q2.14 axis component and 40 bit Q24.16 projection
  typedef logic signed [15:0] comp_t;
  typedef logic signed [39:0] proj_t;

  // c[axis][component]: axis 0 principal, 1 complementary, 2 fixed
  typedef struct packed {
    comp_t [2:0][2:0] c;
  } axes_t;

  // Running extremes of one cloud, handed from front to back
  typedef struct packed {
    logic              seen;
    proj_t [2:0]       mn;
    proj_t [2:0]       mx;
    logic [2:0][15:0]  mn_idx;
    logic [2:0][15:0]  mx_idx;
  } snap_t;

  // One result beat
  typedef struct packed {
    logic [1:0]  axis_id;
    proj_t       min_proj;
    proj_t       max_proj;
    logic [15:0] min_point;
    logic [15:0] max_point;
    logic [38:0] extent;
    proj_t       center_coord;
    logic        last_result;
  } res_t;

  // Saturation limits and rounding offset
  localparam logic signed [63:0] P40_MAX = 64'sd549755813887;
  localparam logic signed [63:0] P40_MIN = -64'sd549755813888;
  localparam logic signed [63:0] EXT_MAX = 64'sd549755813887;
  localparam logic signed [63:0] HALF14  = 64'sd8192;
  localparam logic signed [63:0] COMP_MAX = 64'sd32767;
  localparam logic signed [63:0] COMP_MIN = -64'sd32768;

  // Points with an index at or above this are not compared
  localparam int MAX_POINTS = 65536;

  // Axis identifiers
  localparam logic [1:0] AXIS_PRIN  = 2'd0;
  localparam logic [1:0] AXIS_COMP  = 2'd1;
  localparam logic [1:0] AXIS_FIXED = 2'd2;

  // Configuration register indexes
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_DIR_X   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_DIR_Y   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_DIR_Z   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_FIXED_X = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_FIXED_Y = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_FIXED_Z = 3'd5;

  // Queue depths
  localparam int SNAP_DEPTH = 2;
  localparam int RES_DEPTH  = 2;

endpackage

`default_nettype wire

// ===== design/oriented_box_extent_top.sv =====
// ----------------------------------------------------------------------------
// oriented_box_extent_top: oriented bounding box extent unit
// Projects a point stream onto a configured principal axis, a configured
// fixed axis and their cross product, tracks per-axis extremes and emits
// three result beats per cloud.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   -------   ----------------   ---------------------------------------------
//   points    push / full        point_x/y/z_i, point_index_i, last_point_i
//   results   empty / pop        axis_id_o .. center_coord_o, last_result_o
//   config    cfg_we_i           cfg_addr_i, cfg_wdata_i
//
// One point is taken every cycle while full is low; the compare-update of
// the extremes is a loop on their registers. A point passes stages A and B
// before reaching the extremes. A cloud end yields three result beats, one
// a cycle from the back sequencer while the result queue has room, through
// the snapshot queue, the snapshot register and the product stage. Clouds
// shorter than three points are limited by the back, which issues three
// beats per cloud, with a two-entry snapshot queue in between. full is high
// for one cycle after each configuration write while the cross product axis
// settles. Reset clears all control state and no clearing pass is needed.
//
`default_nettype none

module oriented_box_extent_top #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // points
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic [15:0]                   point_index_i,
  input  logic                          last_point_i,
  // results
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    axis_id_o,
  output logic signed [39:0]            min_proj_o,
  output logic signed [39:0]            max_proj_o,
  output logic [15:0]                   min_point_o,
  output logic [15:0]                   max_point_o,
  output logic [38:0]                   extent_o,
  output logic signed [39:0]            center_coord_o,
  output logic                          last_result_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [obe_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [15:0]                   cfg_wdata_i
);

  import obe_pkg::*;

  comp_t   dir_q [3];
  comp_t   fix_q [3];
  comp_t   comp_q [3], comp_d [3];
  logic    settle_q;
  axes_t   axes;

  logic    front_ready;
  logic    accept;
  logic    snap_push, snap_full, snap_empty, snap_pop;
  snap_t   snap_in, snap_head;
  logic    res_push, res_full;
  res_t    res_in, res_head;

  // Rounded, saturated cross product term a*b - c*e
  function automatic comp_t cross_term(input comp_t a, input comp_t b,
                                       input comp_t c, input comp_t e);
    logic signed [33:0] t;
    logic signed [33:0] s;
    t = $signed(a) * $signed(b) - $signed(c) * $signed(e) + 34'(HALF14);
    s = t >>> 14;
    if (s > 34'(COMP_MAX)) begin
      return COMP_MAX[15:0];
    end else if (s < 34'(COMP_MIN)) begin
      return COMP_MIN[15:0];
    end else begin
      return s[15:0];
    end
  endfunction

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q[0] <= 16'sd16384;
      dir_q[1] <= '0;
      dir_q[2] <= '0;
      fix_q[0] <= '0;
      fix_q[1] <= '0;
      fix_q[2] <= 16'sd16384;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_DIR_X:   dir_q[0] <= cfg_wdata_i;
        CFG_DIR_Y:   dir_q[1] <= cfg_wdata_i;
        CFG_DIR_Z:   dir_q[2] <= cfg_wdata_i;
        CFG_FIXED_X: fix_q[0] <= cfg_wdata_i;
        CFG_FIXED_Y: fix_q[1] <= cfg_wdata_i;
        CFG_FIXED_Z: fix_q[2] <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Complementary axis: fixed cross principal
  always_comb begin
    comp_d[0] = cross_term(fix_q[1], dir_q[2], fix_q[2], dir_q[1]);
    comp_d[1] = cross_term(fix_q[2], dir_q[0], fix_q[0], dir_q[2]);
    comp_d[2] = cross_term(fix_q[0], dir_q[1], fix_q[1], dir_q[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q[0] <= '0;
      comp_q[1] <= 16'sd16384;
      comp_q[2] <= '0;
      settle_q  <= 1'b0;
    end else begin
      comp_q   <= comp_d;
      settle_q <= cfg_we_i;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      axes.c[AXIS_PRIN][c]  = dir_q[c];
      axes.c[AXIS_COMP][c]  = comp_q[c];
      axes.c[AXIS_FIXED][c] = fix_q[c];
    end
  end

  // Hold off points while the front stalls or the axes settle
  assign full   = !front_ready || settle_q;
  assign accept = push && !full;

  obe_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .axes_i        (axes),
    .in_valid_i    (accept),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .point_index_i (point_index_i),
    .last_point_i  (last_point_i),
    .in_ready_o    (front_ready),
    .snap_valid_o  (snap_push),
    .snap_o        (snap_in),
    .snap_full_i   (snap_full)
  );

  obe_fifo #(
    .WIDTH ($bits(snap_t)),
    .DEPTH (SNAP_DEPTH)
  ) u_snap_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .wdata_i (snap_in),
    .full_o  (snap_full),
    .pop_i   (snap_pop),
    .rdata_o (snap_head),
    .empty_o (snap_empty)
  );

  obe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .axes_i       (axes),
    .snap_i       (snap_head),
    .snap_empty_i (snap_empty),
    .snap_pop_o   (snap_pop),
    .res_o        (res_in),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  obe_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_head),
    .empty_o (empty)
  );

  // Present the oldest result beat
  assign axis_id_o      = res_head.axis_id;
  assign min_proj_o     = res_head.min_proj;
  assign max_proj_o     = res_head.max_proj;
  assign min_point_o    = res_head.min_point;
  assign max_point_o    = res_head.max_point;
  assign extent_o       = res_head.extent;
  assign center_coord_o = res_head.center_coord;
  assign last_result_o  = res_head.last_result;

  // Checks
  a_snap_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_push |-> !snap_full)
    else $error("snapshot pushed into a full queue");

  a_res_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_last_on_fixed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_result_o == (axis_id_o == AXIS_FIXED)))
    else $error("last result flag not on the fixed axis beat");

  a_cfg_settle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> full)
    else $error("point accepted before the axes settled");

endmodule

`default_nettype wire

// ===== design/obe_fifo.sv =====
// ----------------------------------------------------------------------------
// obe_fifo: small register queue
// Generic first-in first-out store with full and empty flags; the head entry
// is shown on rdata_o while empty_o is low.
// ----------------------------------------------------------------------------
`default_nettype none

module obe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers, wrapping at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the beat at the write pointer
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/obe_front.sv =====
// ----------------------------------------------------------------------------
// obe_front: point projection and running extremes
// Projects each accepted point onto the three axes in two stages and folds
// the projections into the per-axis minimum and maximum; hands a snapshot of
// the extremes to the back on the last point of a cloud and clears them.
// ----------------------------------------------------------------------------
`default_nettype none

module obe_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  obe_pkg::axes_t                axes_i,
  input  logic                          in_valid_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic [15:0]                   point_index_i,
  input  logic                          last_point_i,
  output logic                          in_ready_o,
  output logic                          snap_valid_o,
  output obe_pkg::snap_t                snap_o,
  input  logic                          snap_full_i
);

  import obe_pkg::*;

  // Product, sum and extended widths
  localparam int PW = COORD_WIDTH + 16;
  localparam int SW = PW + 2;
  localparam int EW = (SW > 54) ? SW : 54;

  logic signed [COORD_WIDTH-1:0] pt [3];

  // Stage A: products
  logic              a_valid_q;
  logic signed [PW-1:0] a_prod_q [3][3];
  logic signed [PW-1:0] a_prod_d [3][3];
  logic [15:0]       a_idx_q;
  logic              a_last_q;
  logic              a_cmp_q;

  // Stage B: projections
  logic              b_valid_q;
  proj_t             b_proj_q [3];
  proj_t             b_proj_d [3];
  logic [15:0]       b_idx_q;
  logic              b_last_q;
  logic              b_cmp_q;

  // Running extremes
  logic              seen_q, seen_d;
  proj_t             mn_q [3], mn_d [3], mn_u [3];
  proj_t             mx_q [3], mx_d [3], mx_u [3];
  logic [15:0]       mni_q [3], mni_d [3], mni_u [3];
  logic [15:0]       mxi_q [3], mxi_d [3], mxi_u [3];

  logic              adv;
  logic              commit;
  logic signed [EW-1:0] sum_w [3];
  logic signed [EW-1:0] shr_w [3];

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  // Stall only while a cloud end waits for room in the snapshot queue
  assign adv          = !(b_valid_q && b_last_q && snap_full_i);
  assign in_ready_o   = adv;
  assign commit       = b_valid_q && adv;
  assign snap_valid_o = b_valid_q && b_last_q && !snap_full_i;

  // Multiply each coordinate by each axis component
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      for (int c = 0; c < 3; c++) begin
        a_prod_d[d][c] = $signed(axes_i.c[d][c]) * pt[c];
      end
    end
  end

  // Sum, round and saturate to 40 bits
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      sum_w[d] = EW'(a_prod_q[d][0]) + EW'(a_prod_q[d][1]) + EW'(a_prod_q[d][2])
               + EW'(HALF14);
      shr_w[d] = sum_w[d] >>> 14;
      if (shr_w[d] > EW'(P40_MAX)) begin
        b_proj_d[d] = P40_MAX[39:0];
      end else if (shr_w[d] < EW'(P40_MIN)) begin
        b_proj_d[d] = P40_MIN[39:0];
      end else begin
        b_proj_d[d] = shr_w[d][39:0];
      end
    end
  end

  // Fold the projection into the extremes; ties keep the earlier point
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      mn_u[d]  = mn_q[d];
      mni_u[d] = mni_q[d];
      mx_u[d]  = mx_q[d];
      mxi_u[d] = mxi_q[d];
      if (b_cmp_q && (!seen_q || (b_proj_q[d] < mn_q[d]))) begin
        mn_u[d]  = b_proj_q[d];
        mni_u[d] = b_idx_q;
      end
      if (b_cmp_q && (!seen_q || (b_proj_q[d] > mx_q[d]))) begin
        mx_u[d]  = b_proj_q[d];
        mxi_u[d] = b_idx_q;
      end
    end
  end

  // Build the snapshot from the updated extremes
  always_comb begin
    snap_o.seen = seen_q | b_cmp_q;
    for (int d = 0; d < 3; d++) begin
      snap_o.mn[d]     = mn_u[d];
      snap_o.mx[d]     = mx_u[d];
      snap_o.mn_idx[d] = mni_u[d];
      snap_o.mx_idx[d] = mxi_u[d];
    end
  end

  // Next extremes: keep, update, or clear after a cloud end
  always_comb begin
    seen_d = seen_q;
    for (int d = 0; d < 3; d++) begin
      mn_d[d]  = mn_q[d];
      mx_d[d]  = mx_q[d];
      mni_d[d] = mni_q[d];
      mxi_d[d] = mxi_q[d];
    end
    if (commit) begin
      if (b_last_q) begin
        seen_d = 1'b0;
        for (int d = 0; d < 3; d++) begin
          mn_d[d]  = P40_MAX[39:0];
          mx_d[d]  = P40_MIN[39:0];
          mni_d[d] = '0;
          mxi_d[d] = '0;
        end
      end else begin
        seen_d = seen_q | b_cmp_q;
        for (int d = 0; d < 3; d++) begin
          mn_d[d]  = mn_u[d];
          mx_d[d]  = mx_u[d];
          mni_d[d] = mni_u[d];
          mxi_d[d] = mxi_u[d];
        end
      end
    end
  end

  // Control state and extremes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      seen_q    <= 1'b0;
      for (int d = 0; d < 3; d++) begin
        mn_q[d]  <= P40_MAX[39:0];
        mx_q[d]  <= P40_MIN[39:0];
        mni_q[d] <= '0;
        mxi_q[d] <= '0;
      end
    end else begin
      if (adv) begin
        a_valid_q <= in_valid_i;
        b_valid_q <= a_valid_q;
      end
      seen_q <= seen_d;
      for (int d = 0; d < 3; d++) begin
        mn_q[d]  <= mn_d[d];
        mx_q[d]  <= mx_d[d];
        mni_q[d] <= mni_d[d];
        mxi_q[d] <= mxi_d[d];
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_prod_q <= a_prod_d;
      a_idx_q  <= point_index_i;
      a_last_q <= last_point_i;
      a_cmp_q  <= (32'(point_index_i) < MAX_POINTS);
      b_proj_q <= b_proj_d;
      b_idx_q  <= a_idx_q;
      b_last_q <= a_last_q;
      b_cmp_q  <= a_cmp_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/obe_back.sv =====
// ----------------------------------------------------------------------------
// obe_back: per-axis result generation
// Takes one cloud snapshot at a time, works out the midpoints, then issues
// one result per axis: extent and the box centre coordinate, rounded and
// saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module obe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  obe_pkg::axes_t axes_i,
  input  obe_pkg::snap_t snap_i,
  input  logic           snap_empty_i,
  output logic           snap_pop_o,
  output obe_pkg::res_t  res_o,
  output logic           res_push_o,
  input  logic           res_full_i
);

  import obe_pkg::*;

  // Sequencer
  logic        busy_q, busy_d;
  logic [1:0]  cnt_q, cnt_d;
  snap_t       cur_q;
  proj_t       dist_q [3], dist_d [3];

  // Product stage
  logic              bm_valid_q;
  logic [1:0]        bm_axis_q;
  logic              bm_last_q;
  logic              bm_seen_q;
  proj_t             bm_mn_q, bm_mx_q;
  logic [15:0]       bm_mni_q, bm_mxi_q;
  logic [38:0]       bm_ext_q, bm_ext_d;
  logic signed [55:0] bm_prod_q [3], bm_prod_d [3];

  logic              adv, issue, last_issue, load;
  logic signed [40:0] ediff;
  logic signed [40:0] mdiff [3];
  logic signed [40:0] mid [3];
  logic signed [57:0] csum, cshr;
  proj_t             cen;

  assign adv        = !bm_valid_q || !res_full_i;
  assign issue      = busy_q && adv;
  assign last_issue = issue && (cnt_q == AXIS_FIXED);
  assign load       = !snap_empty_i && (!busy_q || last_issue);
  assign snap_pop_o = load;
  assign res_push_o = bm_valid_q && !res_full_i;

  // Midpoint per axis from the exact difference
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mdiff[c]  = 41'($signed(snap_i.mx[c])) - 41'($signed(snap_i.mn[c]));
      mid[c]    = 41'($signed(snap_i.mn[c])) + (mdiff[c] >>> 1);
      dist_d[c] = mid[c][39:0];
    end
  end

  // Step through the three axes
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (issue) begin
      cnt_d = (cnt_q == AXIS_FIXED) ? AXIS_PRIN : cnt_q + 1'b1;
    end
    if (load) begin
      busy_d = 1'b1;
    end else if (last_issue) begin
      busy_d = 1'b0;
    end
  end

  // Extent and centre products for the current axis
  always_comb begin
    ediff = 41'($signed(cur_q.mx[cnt_q])) - 41'($signed(cur_q.mn[cnt_q]));
    if (ediff < 41'sd0) begin
      bm_ext_d = '0;
    end else if (ediff > 41'(EXT_MAX)) begin
      bm_ext_d = EXT_MAX[38:0];
    end else begin
      bm_ext_d = ediff[38:0];
    end
    for (int c = 0; c < 3; c++) begin
      bm_prod_d[c] = dist_q[c] * $signed(axes_i.c[c][cnt_q]);
    end
  end

  // Sum, round and saturate the centre coordinate
  always_comb begin
    csum = 58'(bm_prod_q[0]) + 58'(bm_prod_q[1]) + 58'(bm_prod_q[2]) + 58'(HALF14);
    cshr = csum >>> 14;
    if (cshr > 58'(P40_MAX)) begin
      cen = P40_MAX[39:0];
    end else if (cshr < 58'(P40_MIN)) begin
      cen = P40_MIN[39:0];
    end else begin
      cen = cshr[39:0];
    end
  end

  // Drive the result beat; an empty cloud gives zero fields
  always_comb begin
    res_o.axis_id     = bm_axis_q;
    res_o.last_result = bm_last_q;
    if (bm_seen_q) begin
      res_o.min_proj     = bm_mn_q;
      res_o.max_proj     = bm_mx_q;
      res_o.min_point    = bm_mni_q;
      res_o.max_point    = bm_mxi_q;
      res_o.extent       = bm_ext_q;
      res_o.center_coord = cen;
    end else begin
      res_o.min_proj     = '0;
      res_o.max_proj     = '0;
      res_o.min_point    = '0;
      res_o.max_point    = '0;
      res_o.extent       = '0;
      res_o.center_coord = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      cnt_q      <= AXIS_PRIN;
      bm_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (adv) begin
        bm_valid_q <= issue;
      end
    end
  end

  // Snapshot, midpoints and product stage payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q  <= snap_i;
      dist_q <= dist_d;
    end
    if (issue) begin
      bm_axis_q <= cnt_q;
      bm_last_q <= (cnt_q == AXIS_FIXED);
      bm_seen_q <= cur_q.seen;
      bm_mn_q   <= cur_q.mn[cnt_q];
      bm_mx_q   <= cur_q.mx[cnt_q];
      bm_mni_q  <= cur_q.mn_idx[cnt_q];
      bm_mxi_q  <= cur_q.mx_idx[cnt_q];
      bm_ext_q  <= bm_ext_d;
      bm_prod_q <= bm_prod_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the oriented box extent unit
// Streams point clouds through the block under several axis settings, keeps
// an independent prediction of the per-axis extremes, extents and centres,
// and checks every result beat in order against it.
// ----------------------------------------------------------------------------

module tb;
  import obe_pkg::*;

  // Timing of the bench
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_OFF      = 150;
  localparam int STALL_LIMIT   = 1500;
  localparam int RANDOM_POINTS = 100;
  localparam int PHASE_POINTS  = 20;

  // An index that maps to no register; writes to it must be ignored
  localparam logic [CFG_AW-1:0] CFG_UNMAPPED = 3'd7;

  // Running prediction of one cloud and the queue of beats still due
  class extent_tracker;
    longint      regs[6];
    longint      axis_c[3][3];
    longint      lo[3];
    longint      hi[3];
    logic [15:0] lo_idx[3];
    logic [15:0] hi_idx[3];
    bit          seen;
    res_t        beats_due[$];
    int          errors;
    int          beats_seen;

    function new();
      regs = '{16384, 0, 0, 0, 0, 16384};
      errors = 0;
      beats_seen = 0;
      clear_cloud();
    endfunction

    function void clear_cloud();
      for (int d = 0; d < 3; d++) begin
        lo[d] = P40_MAX;
        hi[d] = P40_MIN;
        lo_idx[d] = '0;
        hi_idx[d] = '0;
      end
      seen = 1'b0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] a, logic [15:0] v);
      if (a <= CFG_FIXED_Z) regs[a] = longint'($signed(v));
    endfunction

    function longint clamp(longint v, longint vmin, longint vmax);
      return (v < vmin) ? vmin : ((v > vmax) ? vmax : v);
    endfunction

    // Round half up at 2^-14, floor otherwise
    function longint rnd14(longint v);
      return (v + HALF14) >>> 14;
    endfunction

    function logic [1:0] axis_code(int d);
      case (d)
        0: return AXIS_PRIN;
        1: return AXIS_COMP;
        default: return AXIS_FIXED;
      endcase
    endfunction

    // Principal and fixed axes straight from the registers, the third as
    // fixed cross principal, rounded and clipped to 16 bit
    function void build_axes();
      for (int c = 0; c < 3; c++) begin
        axis_c[0][c] = regs[CFG_DIR_X + c];
        axis_c[2][c] = regs[CFG_FIXED_X + c];
      end
      axis_c[1][0] = clamp(rnd14(axis_c[2][1] * axis_c[0][2] - axis_c[2][2] * axis_c[0][1]),
                           COMP_MIN, COMP_MAX);
      axis_c[1][1] = clamp(rnd14(axis_c[2][2] * axis_c[0][0] - axis_c[2][0] * axis_c[0][2]),
                           COMP_MIN, COMP_MAX);
      axis_c[1][2] = clamp(rnd14(axis_c[2][0] * axis_c[0][1] - axis_c[2][1] * axis_c[0][0]),
                           COMP_MIN, COMP_MAX);
    endfunction

    // Fold one accepted point into the extremes; on the last point of a
    // cloud queue its three beats and start afresh
    function void take_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic [15:0] idx, logic last);
      longint pt[3];
      longint mid[3];
      longint p;
      longint cen;
      longint span;
      res_t   r;
      build_axes();
      pt[0] = longint'(x);
      pt[1] = longint'(y);
      pt[2] = longint'(z);
      if (int'(idx) < MAX_POINTS) begin
        for (int d = 0; d < 3; d++) begin
          p = clamp(rnd14(axis_c[d][0] * pt[0] + axis_c[d][1] * pt[1] + axis_c[d][2] * pt[2]),
                    P40_MIN, P40_MAX);
          // strict compares: a tie keeps the earlier point
          if (!seen || p < lo[d]) begin
            lo[d] = p;
            lo_idx[d] = idx;
          end
          if (!seen || p > hi[d]) begin
            hi[d] = p;
            hi_idx[d] = idx;
          end
        end
        seen = 1'b1;
      end
      if (!last) return;
      for (int d = 0; d < 3; d++) mid[d] = lo[d] + ((hi[d] - lo[d]) >>> 1);
      for (int d = 0; d < 3; d++) begin
        r = '0;
        r.axis_id = axis_code(d);
        r.last_result = (axis_code(d) == AXIS_FIXED);
        if (seen) begin
          // centre component d: sum over axes of midpoint times component d
          cen = clamp(rnd14(mid[0] * axis_c[0][d] + mid[1] * axis_c[1][d]
                            + mid[2] * axis_c[2][d]), P40_MIN, P40_MAX);
          span = clamp(hi[d] - lo[d], 0, EXT_MAX);
          r.min_proj = lo[d][39:0];
          r.max_proj = hi[d][39:0];
          r.min_point = lo_idx[d];
          r.max_point = hi_idx[d];
          r.extent = span[38:0];
          r.center_coord = cen[39:0];
        end
        beats_due.push_back(r);
      end
      clear_cloud();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    task cmp(string field, logic [39:0] got, logic [39:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s: got %h, want %h", beats_seen, field, got, want));
    endtask

    // Check one accepted beat against the oldest one due
    task match_beat(res_t got);
      res_t want;
      beats_seen++;
      if (beats_due.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing due", beats_seen));
        return;
      end
      want = beats_due.pop_front();
      cmp("axis_id", 40'(got.axis_id), 40'(want.axis_id));
      cmp("min_proj", got.min_proj, want.min_proj);
      cmp("max_proj", got.max_proj, want.max_proj);
      cmp("min_point", 40'(got.min_point), 40'(want.min_point));
      cmp("max_point", 40'(got.max_point), 40'(want.max_point));
      cmp("extent", 40'(got.extent), 40'(want.extent));
      cmp("center_coord", got.center_coord, want.center_coord);
      cmp("last_result", 40'(got.last_result), 40'(want.last_result));
    endtask
  endclass

  // Block ports
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic signed [31:0] point_z_i = '0;
  logic [15:0]        point_index_i = '0;
  logic               last_point_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [1:0]         axis_id_o;
  logic signed [39:0] min_proj_o;
  logic signed [39:0] max_proj_o;
  logic [15:0]        min_point_o;
  logic [15:0]        max_point_o;
  logic [38:0]        extent_o;
  logic signed [39:0] center_coord_o;
  logic               last_result_o;
  logic               cfg_we_i = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr_i = '0;
  logic [15:0]        cfg_wdata_i = '0;

  res_t          out_beat;
  extent_tracker sb = new();

  // Bench state shared between processes
  int points_sent = 0;
  int points_taken = 0;
  int clouds_taken = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  int phase = 0;
  bit no_gaps = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_active = 1'b0;

  assign out_beat = {axis_id_o, min_proj_o, max_proj_o, min_point_o, max_point_o,
                     extent_o, center_coord_o, last_result_o};

  oriented_box_extent_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .point_index_i (point_index_i),
    .last_point_i  (last_point_i),
    .empty         (empty),
    .pop           (pop),
    .axis_id_o     (axis_id_o),
    .min_proj_o    (min_proj_o),
    .max_proj_o    (max_proj_o),
    .min_point_o   (min_point_o),
    .max_point_o   (max_point_o),
    .extent_o      (extent_o),
    .center_coord_o(center_coord_o),
    .last_result_o (last_result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] rand_coord();
    int r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (r < 5) return $urandom;
    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
  endfunction

  function automatic logic [15:0] rand_comp();
    int r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 32768)) - 16'd16384;
    if (r < 90) begin
      case ($urandom_range(0, 2))
        0: return 16'd16384;
        1: return 16'hc000;
        default: return 16'h0000;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic int cloud_size();
    int r = $urandom_range(0, 99);
    if (hold_active) return $urandom_range(1, 2);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 12);
    return $urandom_range(20, 30);
  endfunction

  // Offer one point and hold it until the block takes it
  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                            input logic [15:0] idx, input logic last);
    int gap;
    push <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    point_index_i <= idx;
    last_point_i <= last;
    do @(posedge clk_i); while (full);
    points_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // One cloud of random content; some points repeat the previous one to
  // force ties, indices run on or jump
  task automatic send_cloud(input int n);
    logic [31:0] x, y, z;
    logic [15:0] idx;
    bit          seq;
    seq = 1'($urandom_range(0, 1));
    idx = 16'($urandom_range(0, 65535));
    x = rand_coord();
    y = rand_coord();
    z = rand_coord();
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        if ($urandom_range(0, 4) != 0) begin
          x = rand_coord();
          y = rand_coord();
          z = rand_coord();
        end
        idx = seq ? idx + 16'd1 : 16'($urandom_range(0, 65535));
      end
      send_point(x, y, z, idx, i == n - 1);
    end
  endtask

  // Wait for every due beat, then let the pipeline empty
  task automatic settle();
    push <= 1'b0;
    while (sb.beats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(addr, data);
  endtask

  task automatic write_axes(input logic [15:0] dx, input logic [15:0] dy, input logic [15:0] dz,
                            input logic [15:0] fx, input logic [15:0] fy, input logic [15:0] fz);
    cfg_write(CFG_DIR_X, dx);
    cfg_write(CFG_DIR_Y, dy);
    cfg_write(CFG_DIR_Z, dz);
    cfg_write(CFG_FIXED_X, fx);
    cfg_write(CFG_FIXED_Y, fy);
    cfg_write(CFG_FIXED_Z, fz);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  // Result side: random bursts of pop, and on request one long hold-off
  initial begin : sink
    int burst;
    int gap;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_active = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
        hold_active = 1'b0;
        hold_off_req = 1'b0;
      end
      burst = $urandom_range(1, 16);
      pop <= 1'b1;
      repeat (burst) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Sample both handshakes at the edge and run the stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (push && !full) begin
        sb.take_point(point_x_i, point_y_i, point_z_i, point_index_i, last_point_i);
        points_taken++;
        if (last_point_i) clouds_taken++;
        quiet_cycles = 0;
      end
      if (pop && !empty) begin
        sb.match_beat(out_beat);
        quiet_cycles = 0;
      end
      if (cfg_we_i) quiet_cycles = 0;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles, %0d beats still due",
                 quiet_cycles, sb.beats_due.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n;
    int phase_pts;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset axes: single point cloud
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'd0, 1'b1);
    // Coordinate extremes, top index, repeat of the first point as a tie
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'hffff, 1'b0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'd1, 1'b0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'd2, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd3, 1'b1);
    // Identical points: the first index must stick on every axis
    send_point(32'hfffe_8000, 32'h0000_4000, 32'h0004_0000, 16'd10, 1'b0);
    send_point(32'hfffe_8000, 32'h0000_4000, 32'h0004_0000, 16'd11, 1'b0);
    send_point(32'hfffe_8000, 32'h0000_4000, 32'h0004_0000, 16'd12, 1'b1);
    // Smallest steps either side of zero
    send_point(32'hffff_ffff, 32'h0000_0001, 32'h0000_0000, 16'd0, 1'b0);
    send_point(32'h0000_0001, 32'hffff_ffff, 32'h0000_0000, 16'hffff, 1'b1);

    // Full-scale components; principal and fixed axes nearly opposite, so the cross product axis stays near zero
    settle();
    write_axes(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    cfg_write(CFG_UNMAPPED, 16'ha5a5);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'd5, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd6, 1'b0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 16'd7, 1'b1);

    // Diagonal principal axis, vertical fixed axis
    settle();
    write_axes(16'd11585, 16'd11585, 16'd0, 16'd0, 16'd0, 16'd16384);
    send_point(32'h0001_8000, 32'hffff_0000, 32'h0000_2000, 16'd100, 1'b0);
    send_point(32'hfff0_0000, 32'h0003_0000, 32'hffff_c000, 16'd101, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0001, 32'h0010_0000, 16'd102, 1'b0);
    send_point(32'h0002_0000, 32'h0002_0000, 32'hfff8_0000, 16'd103, 1'b0);
    send_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'd104, 1'b1);

    // Random phases, each under its own axis setting
    while (points_sent < 18 + RANDOM_POINTS) begin
      settle();
      case (phase)
        0: write_axes(16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd16384);
        1: write_axes(16'hc000, 16'hc000, 16'hc000, 16'hc000, 16'hc000, 16'hc000);
        2: write_axes(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        default: write_axes(rand_comp(), rand_comp(), rand_comp(),
                            rand_comp(), rand_comp(), rand_comp());
      endcase
      // hold the result side off while short clouds keep coming
      if (phase == 1) begin
        hold_off_req = 1'b1;
        while (!hold_active) @(posedge clk_i);
      end
      no_gaps = (phase == 2);
      phase_pts = 0;
      while (phase_pts < PHASE_POINTS) begin
        n = cloud_size();
        send_cloud(n);
        phase_pts += n;
      end
      no_gaps = 1'b0;
      phase++;
    end

    // Drain and let the pipeline run dry
    push <= 1'b0;
    while (sb.beats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d points in %0d clouds under %0d axis settings, %0d beats checked",
             points_taken, clouds_taken, settings_used + 1, sb.beats_seen);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/obe_pkg.sv
design/obe_fifo.sv
design/obe_front.sv
design/obe_back.sv
design/oriented_box_extent_top.sv
tb/sv/tb.sv
